>>> design/cecte_pkg.sv
// Shared types, constants and timing-word helpers for the CEC frame transmit encoder.
// Depends on nothing; every other design file imports it.
package cecte_pkg;

   // Frame limits and byte counter width.
   localparam int MAX_FRAME_BYTES = 16;
   localparam int COUNT_W         = 5;

   // Queue between the front and the back part.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Field widths.
   localparam int WORD_W = 13;
   localparam int MASK_W = 16;

   // Item command codes.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_ACK  = 1'b1;

   // Destination that marks a broadcast frame.
   localparam logic [3:0] BROADCAST_ADDR = 4'hF;

   // Register index of the own-address mask.
   localparam logic REG_OWN_MASK = 1'b0;

   // Word positions inside the run of one frame byte.
   localparam logic [4:0] STEP_START_DRIVE = 5'd0;
   localparam logic [4:0] STEP_START_REL   = 5'd1;
   localparam logic [4:0] STEP_FIRST_BIT   = 5'd2;
   localparam logic [4:0] STEP_EOM         = 5'd18;
   localparam logic [4:0] STEP_ACK_DRIVE   = 5'd20;
   localparam logic [4:0] STEP_ACK_SAMPLE  = 5'd21;
   localparam logic [4:0] STEP_ACK_REL     = 5'd22;

   // Drive the line low for n time units.
   function automatic logic [WORD_W-1:0] drive_word(input logic [WORD_W-1:0] n);
      return (n - WORD_W'(1)) << 1;
   endfunction

   // Release the line for n time units, optionally sampling it.
   function automatic logic [WORD_W-1:0] release_word(input logic [WORD_W-1:0] n,
                                                      input logic sample);
      return ((n - WORD_W'(1)) << 2) | {{(WORD_W-2){1'b0}}, sample, 1'b1};
   endfunction

   // One classified item waiting for the back part.
   typedef struct packed {
      logic       is_run;
      logic       with_start;
      logic [7:0] data;
      logic       last;
      logic       verdict_valid;
      logic       frame_ok;
      logic       frame_error;
   } entry_type;

   // One result item.
   typedef struct packed {
      logic [WORD_W-1:0] command_word;
      logic              word_valid;
      logic              end_of_run;
      logic              verdict_valid;
      logic              frame_ok;
      logic              frame_error;
   } result_type;

endpackage

>>> design/cecte_front.sv
// Front part: accepts request items, keeps the frame state and classifies each item.
// Depends on cecte_pkg.
module cecte_front
   import cecte_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_command,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   input  logic              req_ack_line_low,
   input  logic [MASK_W-1:0] own_address_mask,
   output logic              push_valid,
   output entry_type         push_entry,
   input  logic              push_ready
);

   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic               broadcast_ff, broadcast_in;
   logic               local_ff, local_in;
   logic               all_acked_ff, all_acked_in;
   logic               overflow_ff, overflow_in;

   logic       accept;
   logic [3:0] src;
   logic [3:0] dst;
   logic       hdr_broadcast;
   logic       hdr_local;
   logic       acked;
   logic       all_acked_next;

   // Items pass straight into the queue when it has room.
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   // Header decode and acknowledge judging.
   assign src            = req_data_byte[7:4];
   assign dst            = req_data_byte[3:0];
   assign hdr_broadcast  = (dst == BROADCAST_ADDR);
   assign hdr_local      = !hdr_broadcast && own_address_mask[src] && own_address_mask[dst];
   assign acked          = local_ff || req_ack_line_low;
   assign all_acked_next = all_acked_ff && (broadcast_ff ? !acked : acked);

   // Classify the item and work out the next frame state.
   always_comb begin
      byte_count_in = byte_count_ff;
      broadcast_in  = broadcast_ff;
      local_in      = local_ff;
      all_acked_in  = all_acked_ff;
      overflow_in   = overflow_ff;
      push_entry    = '0;
      push_entry.data = req_data_byte;
      push_entry.last = req_last_byte;
      if (req_command == CMD_BYTE) begin
         if (byte_count_ff >= COUNT_W'(MAX_FRAME_BYTES)) begin
            // The frame is too long: report an error and drop the byte.
            overflow_in            = 1'b1;
            push_entry.frame_error = 1'b1;
         end else begin
            push_entry.is_run     = 1'b1;
            push_entry.with_start = (byte_count_ff == '0);
            if (byte_count_ff == '0) begin
               broadcast_in = hdr_broadcast;
               local_in     = hdr_local;
               all_acked_in = 1'b1;
            end
            byte_count_in = byte_count_ff + COUNT_W'(1);
         end
      end else begin
         all_acked_in = all_acked_next;
         if (req_last_byte) begin
            // The final sample reports the verdict and closes the frame.
            push_entry.verdict_valid = 1'b1;
            push_entry.frame_ok      = all_acked_next && !overflow_ff && (byte_count_ff != '0);
            push_entry.frame_error   = overflow_ff;
            byte_count_in = '0;
            broadcast_in  = 1'b0;
            local_in      = 1'b0;
            all_acked_in  = 1'b1;
            overflow_in   = 1'b0;
         end
      end
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         broadcast_ff  <= 1'b0;
         local_ff      <= 1'b0;
         all_acked_ff  <= 1'b1;
         overflow_ff   <= 1'b0;
      end else if (accept) begin
         byte_count_ff <= byte_count_in;
         broadcast_ff  <= broadcast_in;
         local_ff      <= local_in;
         all_acked_ff  <= all_acked_in;
         overflow_ff   <= overflow_in;
      end
   end

endmodule

>>> design/cecte_queue.sv
// Short queue of classified items between the front and the back part.
// Depends on cecte_pkg.
module cecte_queue
   import cecte_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  entry_type push_entry,
   output logic      push_ready,
   output logic      pop_valid,
   output entry_type pop_entry,
   input  logic      pop_ready
);

   entry_type          slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    fill_ff, fill_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (fill_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> design/cecte_back.sv
// Back part: emits the result items of each queued item, one per cycle unless stalled.
// Depends on cecte_pkg.
module cecte_back
   import cecte_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  entry_type         pop_entry,
   output logic              pop_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_command_word,
   output logic              rsp_word_valid,
   output logic              rsp_end_of_run,
   output logic              rsp_verdict_valid,
   output logic              rsp_frame_ok,
   output logic              rsp_frame_error
);

   logic       active_ff, active_in;
   entry_type  cur_ff, cur_in;
   logic [4:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   logic       out_free;
   logic       is_final;
   logic       do_load;
   logic       finish;
   logic       do_pop;
   logic [4:0] bit_off;
   logic [2:0] bit_idx;
   logic       bit_value;
   result_type gen;

   // Handshake between the sequencer and the output register.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign is_final  = !cur_ff.is_run || (step_ff == STEP_ACK_REL);
   assign do_load   = active_ff && out_free;
   assign finish    = do_load && is_final;
   assign pop_ready = !active_ff || finish;
   assign do_pop    = pop_valid && pop_ready;

   // Data bits go MSB first, then the end-of-message bit.
   assign bit_off   = step_ff - STEP_FIRST_BIT;
   assign bit_idx   = 3'd7 - bit_off[3:1];
   assign bit_value = (step_ff >= STEP_EOM) ? cur_ff.last : cur_ff.data[bit_idx];

   // Result item for the current step.
   always_comb begin
      gen = '0;
      if (!cur_ff.is_run) begin
         gen.end_of_run    = 1'b1;
         gen.verdict_valid = cur_ff.verdict_valid;
         gen.frame_ok      = cur_ff.frame_ok;
         gen.frame_error   = cur_ff.frame_error;
      end else begin
         gen.word_valid = 1'b1;
         gen.end_of_run = (step_ff == STEP_ACK_REL);
         priority if (step_ff == STEP_START_DRIVE) begin
            gen.command_word = drive_word(WORD_W'(3694));
         end else if (step_ff == STEP_START_REL) begin
            gen.command_word = release_word(WORD_W'(794), 1'b0);
         end else if (step_ff == STEP_ACK_DRIVE) begin
            gen.command_word = drive_word(WORD_W'(594));
         end else if (step_ff == STEP_ACK_SAMPLE) begin
            gen.command_word = release_word(WORD_W'(448), 1'b1);
         end else if (step_ff == STEP_ACK_REL) begin
            gen.command_word = release_word(WORD_W'(1336), 1'b0);
         end else if (!step_ff[0]) begin
            gen.command_word = bit_value ? drive_word(WORD_W'(594))
                                         : drive_word(WORD_W'(1494));
         end else begin
            gen.command_word = bit_value ? release_word(WORD_W'(1794), 1'b0)
                                         : release_word(WORD_W'(894), 1'b0);
         end
      end
   end

   // Sequencer: take the next item as the current one ends.
   always_comb begin
      active_in    = active_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (do_pop) begin
         active_in = 1'b1;
         cur_in    = pop_entry;
         step_in   = pop_entry.with_start ? STEP_START_DRIVE : STEP_FIRST_BIT;
      end else if (finish) begin
         active_in = 1'b0;
      end else if (do_load) begin
         step_in = step_ff + 5'd1;
      end
      if (do_load) begin
         out_valid_in = 1'b1;
         out_in       = gen;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      step_ff <= step_in;
      out_ff  <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_command_word  = out_ff.command_word;
   assign rsp_word_valid    = out_ff.word_valid;
   assign rsp_end_of_run    = out_ff.end_of_run;
   assign rsp_verdict_valid = out_ff.verdict_valid;
   assign rsp_frame_ok      = out_ff.frame_ok;
   assign rsp_frame_error   = out_ff.frame_error;

endmodule

>>> design/cec_frame_transmit_encoder_unit.sv
// Top level of the CEC frame transmit encoder: register port, front, queue and back part.
// Depends on cecte_pkg, cecte_front, cecte_queue and cecte_back.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_ready   command, data_byte, last_byte, ack_line_low
//   rsp_      out        rsp_valid / rsp_ready   command_word, word_valid, end_of_run,
//                                                verdict_valid, frame_ok, frame_error
//   csr_      in         APB, pready tied high   own_address_mask at address 0
//
// A frame byte gives 21 result items, 23 for the first byte of a frame; every other
// item gives one. The back sequencer emits one result item per cycle unless rsp_ready
// stalls it. The front takes an item per cycle while the four-entry queue has room,
// and a result waiting in the output register does not block it.
// Reset is synchronous and active high; it clears the frame state, the queue and the
// output register, and sets the own-address mask to 1.
module cec_frame_transmit_encoder_unit
   import cecte_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_command,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   input  logic              req_ack_line_low,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_command_word,
   output logic              rsp_word_valid,
   output logic              rsp_end_of_run,
   output logic              rsp_verdict_valid,
   output logic              rsp_frame_ok,
   output logic              rsp_frame_error,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [MASK_W-1:0] own_mask_ff;
   logic              csr_write;
   logic              push_valid;
   logic              push_ready;
   entry_type         push_entry;
   logic              pop_valid;
   logic              pop_ready;
   entry_type         pop_entry;

   // Register port: one register, the own-address mask.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_OWN_MASK);
   assign csr_prdata = (csr_paddr[2] == REG_OWN_MASK) ? {{(32-MASK_W){1'b0}}, own_mask_ff}
                                                     : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mask_ff <= MASK_W'(1);
      end else if (csr_write) begin
         own_mask_ff <= csr_pwdata[MASK_W-1:0];
      end
   end

   cecte_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .req_ack_line_low (req_ack_line_low),
      .own_address_mask (own_mask_ff),
      .push_valid       (push_valid),
      .push_entry       (push_entry),
      .push_ready       (push_ready)
   );

   cecte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   cecte_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_entry         (pop_entry),
      .pop_ready         (pop_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_command_word  (rsp_command_word),
      .rsp_word_valid    (rsp_word_valid),
      .rsp_end_of_run    (rsp_end_of_run),
      .rsp_verdict_valid (rsp_verdict_valid),
      .rsp_frame_ok      (rsp_frame_ok),
      .rsp_frame_error   (rsp_frame_error)
   );

endmodule

>>> design/cecte_checker.sv
// Port-level checks for the CEC frame transmit encoder, bound to the top level.
// Depends on cecte_pkg and cec_frame_transmit_encoder_unit.
module cecte_checker
   import cecte_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] rsp_command_word,
   input logic              rsp_word_valid,
   input logic              rsp_end_of_run,
   input logic              rsp_verdict_valid,
   input logic              rsp_frame_ok,
   input logic              rsp_frame_error,
   input logic              csr_pready
);

   // A stalled result item holds its timing word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_command_word))
      else $error("stalled result item changed");

   // A result item without a timing word always closes its run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word_valid |-> rsp_end_of_run && (rsp_command_word == '0))
      else $error("wordless result item does not end its run");

   // Timing words never carry verdict or error flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word_valid |-> !rsp_verdict_valid && !rsp_frame_ok && !rsp_frame_error)
      else $error("timing word carries frame status");

   // A good frame is never reported together with an error.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok |-> rsp_verdict_valid && !rsp_frame_error)
      else $error("frame_ok outside a clean verdict");

   // The register port never inserts wait states.
   assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr_pready dropped");

endmodule

bind cec_frame_transmit_encoder_unit cecte_checker u_cecte_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_command_word  (rsp_command_word),
   .rsp_word_valid    (rsp_word_valid),
   .rsp_end_of_run    (rsp_end_of_run),
   .rsp_verdict_valid (rsp_verdict_valid),
   .rsp_frame_ok      (rsp_frame_ok),
   .rsp_frame_error   (rsp_frame_error),
   .csr_pready        (csr_pready)
);

>>> bench/cec_frame_transmit_encoder_unit_test.sv
// Self-checking testbench for the CEC frame transmit encoder: drives frame bytes and
// acknowledge samples, predicts every timing word and verdict, and checks each result.
// Depends on cecte_pkg and cec_frame_transmit_encoder_unit.
module cec_frame_transmit_encoder_unit_test
   import cecte_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Bus timing of the encoded symbols, in line time units.
   localparam int START_LOW       = 3694;
   localparam int START_HIGH      = 794;
   localparam int ZERO_LOW        = 1494;
   localparam int ZERO_HIGH       = 894;
   localparam int ONE_LOW         = 594;
   localparam int ONE_HIGH        = 1794;
   localparam int ACK_LOW         = 594;
   localparam int ACK_SAMPLE_HIGH = 448;
   localparam int ACK_TAIL_HIGH   = 1336;

   localparam logic [2:0] OWN_MASK_ADDR = 3'(4 * int'(REG_OWN_MASK));
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 96;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_command = CMD_BYTE;
   logic [7:0]        req_data_byte = 8'h00;
   logic              req_last_byte = 1'b0;
   logic              req_ack_line_low = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [WORD_W-1:0] rsp_command_word;
   logic              rsp_word_valid;
   logic              rsp_end_of_run;
   logic              rsp_verdict_valid;
   logic              rsp_frame_ok;
   logic              rsp_frame_error;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [2:0]        csr_paddr = 3'd0;
   logic [31:0]       csr_pwdata = 32'd0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   // Predicted encoder state and the words it still owes.
   logic [MASK_W-1:0]  own_mask = MASK_W'(1);
   logic [COUNT_W-1:0] frame_bytes = '0;
   logic               is_broadcast = 1'b0;
   logic               is_local = 1'b0;
   logic               acks_good = 1'b1;
   logic               overflowed = 1'b0;
   result_type         expected_results[$];

   // Run bookkeeping.
   bit no_idle = 1'b0;
   int failures = 0;
   int items_sent = 0;
   int results_seen = 0;
   int verdicts_total = 0;
   int verdicts_good = 0;
   int bytes_dropped = 0;
   int quiet_cycles = 0;

   cec_frame_transmit_encoder_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .req_ack_line_low  (req_ack_line_low),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_command_word  (rsp_command_word),
      .rsp_word_valid    (rsp_word_valid),
      .rsp_end_of_run    (rsp_end_of_run),
      .rsp_verdict_valid (rsp_verdict_valid),
      .rsp_frame_ok      (rsp_frame_ok),
      .rsp_frame_error   (rsp_frame_error),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // Free-running clock, 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Count a failure; only the first few are described.
   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // Timing word that pulls the line low for n units.
   function automatic logic [WORD_W-1:0] low_time_word(input int n);
      return WORD_W'((n - 1) << 1);
   endfunction

   // Timing word that lets the line go for n units, sampling it if asked.
   function automatic logic [WORD_W-1:0] high_time_word(input int n, input bit sample);
      return WORD_W'(((n - 1) << 2) | (sample ? 3 : 1));
   endfunction

   function automatic void queue_result(input logic [WORD_W-1:0] word, input logic valid,
                                        input logic run_end, input logic verdict,
                                        input logic ok, input logic error);
      result_type r;
      r.command_word  = word;
      r.word_valid    = valid;
      r.end_of_run    = run_end;
      r.verdict_valid = verdict;
      r.frame_ok      = ok;
      r.frame_error   = error;
      expected_results.push_back(r);
   endfunction

   // One data or end-of-message bit: a low phase and a release phase.
   function automatic void queue_bit_words(input logic one);
      queue_result(low_time_word(one ? ONE_LOW : ZERO_LOW), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_result(high_time_word(one ? ONE_HIGH : ZERO_HIGH, 1'b0),
                   1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
   endfunction

   // Work out the results of one accepted item and advance the predicted state.
   function automatic void predict_encoder(input logic cmd, input logic [7:0] data,
                                           input logic last, input logic low);
      logic acked;
      logic ok;
      if (cmd == CMD_BYTE) begin
         if (int'(frame_bytes) >= MAX_FRAME_BYTES) begin
            // Oversize frame: the byte is dropped and flagged.
            overflowed = 1'b1;
            bytes_dropped++;
            queue_result('0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
            return;
         end
         if (frame_bytes == '0) begin
            // Header byte: decide the frame mode and emit the start bit.
            is_broadcast = (data[3:0] == BROADCAST_ADDR);
            is_local = !is_broadcast && own_mask[data[7:4]] && own_mask[data[3:0]];
            acks_good = 1'b1;
            queue_result(low_time_word(START_LOW), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            queue_result(high_time_word(START_HIGH, 1'b0), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
         end
         for (int b = 7; b >= 0; b--) begin
            queue_bit_words(data[b]);
         end
         queue_bit_words(last);
         queue_result(low_time_word(ACK_LOW), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
         queue_result(high_time_word(ACK_SAMPLE_HIGH, 1'b1), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
         queue_result(high_time_word(ACK_TAIL_HIGH, 1'b0), 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
         frame_bytes = frame_bytes + 1'b1;
         return;
      end
      // Acknowledge sample: broadcast frames expect no acknowledge.
      acked = is_local ? 1'b1 : low;
      acks_good = acks_good & (is_broadcast ? !acked : acked);
      if (!last) begin
         queue_result('0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
         return;
      end
      ok = acks_good && !overflowed && (frame_bytes != '0);
      queue_result('0, 1'b0, 1'b1, 1'b1, ok, overflowed);
      verdicts_total++;
      if (ok) begin
         verdicts_good++;
      end
      frame_bytes = '0;
      is_broadcast = 1'b0;
      is_local = 1'b0;
      acks_good = 1'b1;
      overflowed = 1'b0;
   endfunction

   // Present one item, wait for it to be taken, then predict its results.
   task automatic send_item(input logic cmd, input logic [7:0] data, input logic last,
                            input logic low);
      while (!no_idle && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_command      <= cmd;
      req_data_byte    <= data;
      req_last_byte    <= last;
      req_ack_line_low <= low;
      req_valid        <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_encoder(cmd, data, last, low);
      items_sent++;
      @(negedge clock);
   endtask

   // Stop sending and let every owed result come out, then a little longer.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Read the own-address mask and compare it with the predicted value.
   task automatic check_own_mask();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= OWN_MASK_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== 32'(own_mask)) begin
         note_failure($sformatf("own mask read back %h, expected %h", csr_prdata,
                                32'(own_mask)));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Write the own-address mask through the register port and read it back.
   task automatic write_own_mask(input logic [MASK_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= OWN_MASK_ADDR;
      csr_pwdata  <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      own_mask = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      check_own_mask();
   endtask

   // A logical address this device owns, or any address when it owns none.
   function automatic logic [3:0] pick_owned();
      logic [3:0] a;
      a = 4'($urandom);
      if (own_mask == '0) begin
         return a;
      end
      while (!own_mask[a]) a = 4'($urandom);
      return a;
   endfunction

   // Header mix: local-looking, broadcast and arbitrary.
   function automatic logic [7:0] pick_header();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         return {pick_owned(), pick_owned()};
      end else if (r < 60) begin
         return {4'($urandom), BROADCAST_ADDR};
      end
      return 8'($urandom);
   endfunction

   // A frame of bytes followed by its acknowledge samples; a broken one may have stray
   // end markers and a wrong number of samples.
   task automatic send_frame(input bit well_formed);
      int   nbytes;
      int   nacks;
      bit   perfect;
      logic good_low;
      logic mark;
      nbytes = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4)
                                            : $urandom_range(5, MAX_FRAME_BYTES);
      perfect = 1'($urandom_range(0, 1));
      for (int i = 0; i < nbytes; i++) begin
         mark = well_formed ? (i == nbytes - 1) : 1'($urandom_range(0, 1));
         send_item(CMD_BYTE, (i == 0) ? pick_header() : 8'($urandom), mark,
                   1'($urandom_range(0, 1)));
      end
      good_low = !is_broadcast;
      nacks = well_formed ? nbytes : $urandom_range(0, nbytes + 1);
      for (int i = 0; i < nacks; i++) begin
         mark = (i == nacks - 1) ? (well_formed || $urandom_range(0, 1))
                                 : (!well_formed && $urandom_range(0, 9) == 0);
         send_item(CMD_ACK, 8'($urandom), mark,
                   (perfect || $urandom_range(0, 99) < 80) ? good_low : !good_low);
      end
   endtask

   // A frame longer than the limit, closed by one final sample.
   task automatic send_oversize_frame();
      int nbytes;
      nbytes = $urandom_range(MAX_FRAME_BYTES + 1, MAX_FRAME_BYTES + 2);
      for (int i = 0; i < nbytes; i++) begin
         send_item(CMD_BYTE, (i == 0) ? pick_header() : 8'($urandom), i == nbytes - 1,
                   1'($urandom_range(0, 1)));
      end
      send_item(CMD_ACK, 8'($urandom), 1'b1, 1'($urandom_range(0, 1)));
   endtask

   // Reset value of the mask.
   task automatic test_reset_mask();
      check_own_mask();
   endtask

   // Empty frame, stray sample, local, broadcast and plain unicast frames,
   // with all-zero and all-one data bytes.
   task automatic test_basic_frames();
      send_item(CMD_ACK, 8'h00, 1'b1, 1'b1);
      send_item(CMD_ACK, 8'hFF, 1'b0, 1'b0);
      send_item(CMD_BYTE, 8'h00, 1'b0, 1'b0);
      send_item(CMD_BYTE, 8'hFF, 1'b1, 1'b1);
      send_item(CMD_ACK, 8'h00, 1'b0, 1'b0);
      send_item(CMD_ACK, 8'h00, 1'b1, 1'b0);
      send_item(CMD_BYTE, 8'h1F, 1'b0, 1'b0);
      send_item(CMD_BYTE, 8'hA5, 1'b1, 1'b0);
      send_item(CMD_ACK, 8'h00, 1'b0, 1'b0);
      send_item(CMD_ACK, 8'h00, 1'b1, 1'b1);
      send_item(CMD_BYTE, 8'h10, 1'b1, 1'b0);
      send_item(CMD_ACK, 8'h00, 1'b1, 1'b1);
   endtask

   // Seventeen bytes in one frame: the last one is dropped and the verdict flags it.
   task automatic test_frame_overflow();
      for (int i = 0; i <= MAX_FRAME_BYTES; i++) begin
         send_item(CMD_BYTE, (i == 0) ? 8'h00 : 8'($urandom), i == MAX_FRAME_BYTES, 1'b1);
      end
      send_item(CMD_ACK, 8'h00, 1'b1, 1'b1);
   endtask

   // One mask setting with mostly well-formed frames, some broken ones and noise.
   task automatic test_random_traffic(input logic [MASK_W-1:0] mask, input bit steady);
      int goal;
      int pick;
      wait_until_idle();
      write_own_mask(mask);
      no_idle = steady;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            send_frame(1'b1);
         end else if (pick < 86) begin
            send_frame(1'b0);
         end else if (pick < 89) begin
            send_oversize_frame();
         end else begin
            send_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end
         // Now and then hold off until the encoder has caught up.
         if ($urandom_range(0, 99) < 4) begin
            wait_until_idle();
         end
      end
      no_idle = 1'b0;
   endtask

   // Result side stalls at random except during the steady stretch.
   always @(negedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 11);
   end

   // Compare each result taken with the oldest one owed.
   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.command_word  = rsp_command_word;
         seen.word_valid    = rsp_word_valid;
         seen.end_of_run    = rsp_end_of_run;
         seen.verdict_valid = rsp_verdict_valid;
         seen.frame_ok      = rsp_frame_ok;
         seen.frame_error   = rsp_frame_error;
         results_seen++;
         if (expected_results.size() == 0) begin
            note_failure($sformatf("result %0d arrived with none owed: word %h valid %b",
                                   results_seen, seen.command_word, seen.word_valid));
         end else begin
            want = expected_results.pop_front();
            if (seen.command_word !== want.command_word ||
                seen.word_valid !== want.word_valid ||
                seen.end_of_run !== want.end_of_run ||
                seen.verdict_valid !== want.verdict_valid ||
                seen.frame_ok !== want.frame_ok ||
                seen.frame_error !== want.frame_error) begin
               note_failure($sformatf({"result %0d mismatch: expected word %h valid %b ",
                                       "end %b verdict %b ok %b error %b, got word %h ",
                                       "valid %b end %b verdict %b ok %b error %b"},
                                      results_seen, want.command_word, want.word_valid,
                                      want.end_of_run, want.verdict_valid, want.frame_ok,
                                      want.frame_error, seen.command_word,
                                      seen.word_valid, seen.end_of_run,
                                      seen.verdict_valid, seen.frame_ok,
                                      seen.frame_error));
            end
         end
      end
   end

   // Watchdog: too long without any handshake ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timed out with %0d results still owed.", expected_results.size());
            $display("FAIL cec_frame_transmit_encoder_unit");
            $finish;
         end
      end
   end

   // Test sequence.
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_mask();
      test_basic_frames();
      test_frame_overflow();
      test_random_traffic(16'hFFFF, 1'b1);
      test_random_traffic(16'h0000, 1'b0);
      test_random_traffic(16'($urandom), 1'b0);
      test_random_traffic(16'h8001, 1'b0);
      wait_until_idle();
      if (expected_results.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", expected_results.size()));
      end
      $display("Sent %0d items over five mask settings and checked %0d results.",
               items_sent, results_seen);
      $display("Frames closed: %0d (%0d good); oversize bytes dropped: %0d; failures: %0d.",
               verdicts_total, verdicts_good, bytes_dropped, failures);
      if (failures == 0) begin
         $display("PASS cec_frame_transmit_encoder_unit");
      end else begin
         $display("FAIL cec_frame_transmit_encoder_unit");
      end
      $finish;
   end

endmodule
